@@ rtl/core/i2p_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package i2p_pkg;

  localparam int unsigned STACK_DEPTH  = 32;
  localparam int unsigned PAYLOAD_BITS = 32;

  // widths fixed by the port fields
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned OP_W       = 4;
  localparam int unsigned PORT_PAY_W = 32;

  // input token kinds
  localparam logic [KIND_W-1:0] KIND_OPERAND = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FUNC    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OPER    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_OPEN    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLOSE   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_END     = 3'd5;

  // emitted token kinds
  localparam logic [1:0] OUT_OPERAND = 2'd0;
  localparam logic [1:0] OUT_FUNC    = 2'd1;
  localparam logic [1:0] OUT_OPER    = 2'd2;

  // operator codes that bound the precedence groups
  localparam logic [OP_W-1:0] OP_POW  = 4'd0;
  localparam logic [OP_W-1:0] OP_OF   = 4'd4;
  localparam logic [OP_W-1:0] OP_SUB  = 4'd6;
  localparam logic [OP_W-1:0] OP_LAST = 4'd12;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_INVALID  = 2'd3;

  localparam logic [5:0] PREC_POW = 6'd40;
  localparam logic [5:0] PREC_MUL = 6'd30;
  localparam logic [5:0] PREC_ADD = 6'd20;
  localparam logic [5:0] PREC_CMP = 6'd10;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
    logic is_open;
  } stk_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic has_open;
  } stk_status_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [OP_W-1:0]       op;
    logic [PORT_PAY_W-1:0] payload;
    logic [1:0]            status;
  } res_t;

  function automatic logic [5:0] prec_of(input logic [OP_W-1:0] op);
    logic [5:0] p;
    if (op == OP_POW) begin
      p = PREC_POW;
    end else if (op <= OP_OF) begin
      p = PREC_MUL;
    end else if (op <= OP_SUB) begin
      p = PREC_ADD;
    end else begin
      p = PREC_CMP;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/i2p_stack.sv @@
`timescale 1ns / 1ps
`default_nettype none

module i2p_stack #(
  parameter int unsigned DEPTH = i2p_pkg::STACK_DEPTH,
  parameter int unsigned ENT_W = i2p_pkg::KIND_W + i2p_pkg::OP_W + i2p_pkg::PAYLOAD_BITS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire i2p_pkg::stk_cmd_t    cmd_i,
  input  wire logic [ENT_W-1:0]     wr_entry_i,
  output i2p_pkg::stk_status_t      status_o,
  output logic [ENT_W-1:0]          top_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);

  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] top_q;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    open_q, open_d;
  logic [CW-1:0]    cnt_m1;
  logic [AW-1:0]    rd_addr, wr_addr;

  assign cnt_m1  = count_q - CW'(1);
  assign rd_addr = cnt_m1[AW-1:0];
  assign wr_addr = count_q[AW-1:0];

  // the read port always follows the current top; its data is registered, so it
  // is good in the cycle after the count settles
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wr_addr] <= wr_entry_i;
    end
    top_q <= mem[rd_addr];
  end

  always_comb begin
    count_d = count_q;
    open_d  = open_q;
    if (cmd_i.clear) begin
      count_d = '0;
      open_d  = '0;
    end else if (cmd_i.push) begin
      count_d = count_q + CW'(1);
      if (cmd_i.is_open) begin
        open_d = open_q + CW'(1);
      end
    end else if (cmd_i.pop) begin
      count_d = cnt_m1;
      if (cmd_i.is_open) begin
        open_d = open_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      open_q  <= '0;
    end else begin
      count_q <= count_d;
      open_q  <= open_d;
    end
  end

  assign status_o.empty    = (count_q == '0);
  assign status_o.full     = (count_q == CW'(DEPTH));
  assign status_o.has_open = (open_q != '0);
  assign top_o             = top_q;

`ifndef SYNTHESIS
  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push && !cmd_i.clear |-> count_q != CW'(DEPTH))
    else $error("push onto a full stack");

  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop && !cmd_i.clear |-> count_q != '0)
    else $error("pop from an empty stack");

  a_open_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= count_q)
    else $error("open paren count above stack count");

  a_push_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push && !cmd_i.clear |=> count_q == $past(count_q) + CW'(1))
    else $error("push did not advance the count");
`endif

endmodule

`default_nettype wire

@@ rtl/core/infix_to_postfix_converter_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Shunting-yard infix to postfix converter. One token is taken per transfer on
// the input side and the postfix tokens it releases leave one per transfer on
// the output side, the final one of each token marked by last. The operator
// stack sits in a synchronous memory with one write and one read port, the
// read port always tracking the top of stack. A token goes through the accept,
// evaluate and release states, and every entry it pops adds a wait state and
// another evaluation, since each pop has to wait for the memory's registered
// read of the new top; the function released right after its close parenthesis
// needs no wait state. Output back-pressure can stall evaluate and release.
// After an error one status result is sent, the stack is dropped and all
// tokens up to and including the next end token are swallowed without result.
// Reset leaves the stack empty; no clearing pass is needed.
module infix_to_postfix_converter_unit #(
  parameter int unsigned STACK_DEPTH  = i2p_pkg::STACK_DEPTH,
  parameter int unsigned PAYLOAD_BITS = i2p_pkg::PAYLOAD_BITS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [i2p_pkg::KIND_W-1:0]       token_kind_i,
  input  wire logic [i2p_pkg::OP_W-1:0]         op_code_i,
  input  wire logic [i2p_pkg::PORT_PAY_W-1:0]   token_payload_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [1:0]                            out_kind_o,
  output logic [i2p_pkg::OP_W-1:0]              out_op_o,
  output logic [i2p_pkg::PORT_PAY_W-1:0]        out_payload_o,
  output logic [1:0]                            status_o,
  output logic                                  last_o
);

  localparam int unsigned KW     = i2p_pkg::KIND_W;
  localparam int unsigned OW     = i2p_pkg::OP_W;
  localparam int unsigned PW     = i2p_pkg::PORT_PAY_W;
  localparam int unsigned ENT_W  = KW + OW + PAYLOAD_BITS;
  localparam int unsigned WIDE_W = (PAYLOAD_BITS > PW) ? PAYLOAD_BITS : PW;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]              state_q, state_d;
  logic                    hold_q, hold_d;
  logic                    phase_q, phase_d;   // close paren: its open is gone
  logic [KW-1:0]           tok_kind_q;
  logic [OW-1:0]           tok_op_q;
  logic [PAYLOAD_BITS-1:0] tok_pay_q;
  logic [WIDE_W-1:0]       tok_wide;
  logic [WIDE_W-1:0]       in_wide;

  i2p_pkg::stk_cmd_t       cmd;
  i2p_pkg::stk_status_t    stk;
  logic [ENT_W-1:0]        wr_entry;
  logic [ENT_W-1:0]        top;
  logic [KW-1:0]           top_kind;
  logic [OW-1:0]           top_op;
  logic [WIDE_W-1:0]       top_wide;

  i2p_pkg::res_t           pend_q, pend_d, new_res, pop_res, out_q, out_res;
  logic                    pend_v_q, pend_v_d;
  logic                    out_v_q, out_last_q, out_last;
  logic                    out_load, out_free, gate;
  logic                    in_accept;
  logic                    err;
  logic [1:0]              err_code;
  logic                    emit;

  i2p_stack #(
    .DEPTH (STACK_DEPTH),
    .ENT_W (ENT_W)
  ) u_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .wr_entry_i (wr_entry),
    .status_o   (stk),
    .top_o      (top)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign in_wide    = WIDE_W'(token_payload_i);
  assign tok_wide   = WIDE_W'(tok_pay_q);

  assign top_kind = top[ENT_W-1 -: KW];
  assign top_op   = top[PAYLOAD_BITS +: OW];
  assign top_wide = WIDE_W'(top[PAYLOAD_BITS-1:0]);

  always_comb begin
    pop_res = '0;
    if (top_kind == i2p_pkg::KIND_OPER) begin
      pop_res.kind = i2p_pkg::OUT_OPER;
      pop_res.op   = top_op;
    end else begin
      pop_res.kind    = i2p_pkg::OUT_FUNC;
      pop_res.payload = top_wide[PW-1:0];
    end
    pop_res.status = i2p_pkg::ST_OK;
  end

  always_comb begin
    wr_entry = '0;
    wr_entry[ENT_W-1 -: KW] = tok_kind_q;
    if (tok_kind_q == i2p_pkg::KIND_OPER) begin
      wr_entry[PAYLOAD_BITS +: OW] = tok_op_q;
    end
    if (tok_kind_q == i2p_pkg::KIND_FUNC) begin
      wr_entry[PAYLOAD_BITS-1:0] = tok_pay_q;
    end
  end

  assign out_free = !out_v_q || out_ready_i;
  // a new result may enter pend only if the old one can move on
  assign gate     = !pend_v_q || out_free;

  always_comb begin
    state_d  = state_q;
    hold_d   = hold_q;
    phase_d  = phase_q;
    cmd      = '0;
    new_res  = '0;
    emit     = 1'b0;
    err      = 1'b0;
    err_code = i2p_pkg::ST_OK;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EVAL;
          phase_d = 1'b0;
        end
      end
      S_EVAL: begin
        if (hold_q) begin
          if (tok_kind_q == i2p_pkg::KIND_END) begin
            cmd.clear = 1'b1;
            hold_d    = 1'b0;
          end
          state_d = S_FLUSH;
        end else begin
          case (tok_kind_q)
            i2p_pkg::KIND_OPERAND: begin
              new_res.kind    = i2p_pkg::OUT_OPERAND;
              new_res.payload = tok_wide[PW-1:0];
              if (gate) begin
                emit    = 1'b1;
                state_d = S_FLUSH;
              end
            end
            i2p_pkg::KIND_FUNC, i2p_pkg::KIND_OPEN: begin
              if (stk.full) begin
                err      = 1'b1;
                err_code = i2p_pkg::ST_OVERFLOW;
              end else begin
                cmd.push    = 1'b1;
                cmd.is_open = (tok_kind_q == i2p_pkg::KIND_OPEN);
                state_d     = S_FLUSH;
              end
            end
            i2p_pkg::KIND_OPER: begin
              if (tok_op_q > i2p_pkg::OP_LAST) begin
                err      = 1'b1;
                err_code = i2p_pkg::ST_INVALID;
              end else if (!stk.empty && top_kind == i2p_pkg::KIND_OPER &&
                           i2p_pkg::prec_of(top_op) >= i2p_pkg::prec_of(tok_op_q)) begin
                new_res = pop_res;
                if (gate) begin
                  emit    = 1'b1;
                  cmd.pop = 1'b1;
                  state_d = S_WAIT;
                end
              end else if (stk.full) begin
                err      = 1'b1;
                err_code = i2p_pkg::ST_OVERFLOW;
              end else begin
                cmd.push = 1'b1;
                state_d  = S_FLUSH;
              end
            end
            i2p_pkg::KIND_CLOSE: begin
              if (phase_q) begin
                if (!stk.empty && top_kind == i2p_pkg::KIND_FUNC) begin
                  new_res = pop_res;
                  if (gate) begin
                    emit    = 1'b1;
                    cmd.pop = 1'b1;
                    state_d = S_FLUSH;
                  end
                end else begin
                  state_d = S_FLUSH;
                end
              end else if (!stk.has_open) begin
                err      = 1'b1;
                err_code = i2p_pkg::ST_MISMATCH;
              end else if (top_kind != i2p_pkg::KIND_OPEN) begin
                new_res = pop_res;
                if (gate) begin
                  emit    = 1'b1;
                  cmd.pop = 1'b1;
                  state_d = S_WAIT;
                end
              end else begin
                // drop the matching open paren, then look for a function
                cmd.pop     = 1'b1;
                cmd.is_open = 1'b1;
                phase_d     = 1'b1;
                state_d     = S_WAIT;
              end
            end
            i2p_pkg::KIND_END: begin
              if (stk.has_open) begin
                err      = 1'b1;
                err_code = i2p_pkg::ST_MISMATCH;
              end else if (!stk.empty) begin
                new_res = pop_res;
                if (gate) begin
                  emit    = 1'b1;
                  cmd.pop = 1'b1;
                  state_d = S_WAIT;
                end
              end else begin
                state_d = S_FLUSH;
              end
            end
            default: begin
              err      = 1'b1;
              err_code = i2p_pkg::ST_INVALID;
            end
          endcase

          // errors are found before anything is emitted, so pend is empty here
          if (err) begin
            new_res        = '0;
            new_res.status = err_code;
            cmd            = '0;
            if (gate) begin
              emit      = 1'b1;
              cmd.clear = 1'b1;
              hold_d    = 1'b1;
              state_d   = S_FLUSH;
            end
          end
        end
      end
      S_WAIT: begin
        state_d = S_EVAL;
      end
      S_FLUSH: begin
        if (!pend_v_q || out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // pend holds the newest result until it is known whether another follows
  always_comb begin
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    out_load = 1'b0;
    out_res  = pend_q;
    out_last = 1'b0;
    if (emit) begin
      pend_d   = new_res;
      pend_v_d = 1'b1;
      out_load = pend_v_q;
    end else if (state_q == S_FLUSH && pend_v_q && out_free) begin
      pend_v_d = 1'b0;
      out_load = 1'b1;
      out_last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      hold_q   <= 1'b0;
      phase_q  <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      hold_q   <= hold_d;
      phase_q  <= phase_d;
      pend_v_q <= pend_v_d;
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      tok_kind_q <= token_kind_i;
      tok_op_q   <= op_code_i;
      tok_pay_q  <= in_wide[PAYLOAD_BITS-1:0];
    end
    pend_q <= pend_d;
    if (out_load) begin
      out_q      <= out_res;
      out_last_q <= out_last;
    end
  end

  assign out_valid_o   = out_v_q;
  assign out_kind_o    = out_q.kind;
  assign out_op_o      = out_q.op;
  assign out_payload_o = out_q.payload;
  assign status_o      = out_q.status;
  assign last_o        = out_last_q;

endmodule

`default_nettype wire
